FILE: design/mcpwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcpwm_pkg
// Shared constants for the multichannel PWM generator with master dimming.
// ----------------------------------------------------------------------------
package mcpwm_pkg;

    localparam int CHANNELS_PER_DEVICE = 32;
    localparam int DEF_DEVICE_COUNT    = 3;
    localparam int DEF_GLYPH_COUNT     = 96;

    localparam int CHAN_W       = 5;
    localparam int DEV_W        = 2;
    localparam int GLYPH_W      = 7;
    localparam int DUTY_W       = 8;
    localparam int PROD_W       = 2 * DUTY_W;
    localparam int DATA_IN_W    = 16;
    localparam int DATA_OUT_W   = 40;

    localparam logic [CHAN_W-1:0] CHAN_LAST    = 5'h1F;
    localparam logic [DUTY_W-1:0] DUTY_CLAMP   = 8'd254;
    localparam logic [DUTY_W-1:0] MASTER_RESET = 8'd255;
    localparam logic [PROD_W-1:0] ROUND_BIAS   = 16'd127;

    localparam logic CMD_SET  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

endpackage

FILE: design/mcpwm_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcpwm_scale
// Level times master intensity, rounded divide by 255, clamp to 254.
// ----------------------------------------------------------------------------
module mcpwm_scale (
    input  logic                          i_clk,
    input  logic [mcpwm_pkg::DUTY_W-1:0]  i_level,
    input  logic [mcpwm_pkg::DUTY_W-1:0]  i_master,
    output logic [mcpwm_pkg::DUTY_W-1:0]  o_duty
);
    import mcpwm_pkg::*;

    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] w_biased;
    logic [PROD_W-1:0] w_sum;
    logic [DUTY_W-1:0] w_quot;

    // register the product before the reduction
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_level) * PROD_W'(i_master);
    end

    // x / 255 for x below 65535 is (x + 1 + (x >> 8)) >> 8
    always_comb begin
        w_biased = r_prod + ROUND_BIAS;
        w_sum    = w_biased + PROD_W'(1) + (w_biased >> DUTY_W);
        w_quot   = w_sum[PROD_W-1:DUTY_W];
        o_duty   = (w_quot >= DUTY_CLAMP) ? DUTY_CLAMP : w_quot;
    end

endmodule

FILE: design/mcpwm_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcpwm_store
// Duty memory: one write and one registered read port, per-entry valid bits.
// ----------------------------------------------------------------------------
module mcpwm_store #(
    parameter int DEPTH = mcpwm_pkg::DEF_DEVICE_COUNT * mcpwm_pkg::CHANNELS_PER_DEVICE,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [AW-1:0]                 i_wr_addr,
    input  logic [mcpwm_pkg::DUTY_W-1:0]  i_wr_data,
    input  logic [AW-1:0]                 i_rd_addr,
    output logic [mcpwm_pkg::DUTY_W-1:0]  o_rd_data
);
    import mcpwm_pkg::*;

    logic [DUTY_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_vld;
    logic [DUTY_W-1:0] r_rd_data;
    logic              r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // an entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

FILE: design/multichannel_pwm_with_master_dimming_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_pwm_with_master_dimming_top
// PWM generator for DEVICE_COUNT x 32 channels with master dimming.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_axis channel. tuser carries the command: set
//   stores a scaled level for a glyph, tick produces one 32-bit word per
//   device on m_axis, device 0 first, tlast on the final word.
//   The cfg channel writes the master intensity; it is always ready and
//   should only be written while the block is idle.
// Timing:
//   A set runs through accept, multiply and memory write; a glyph at or
//   above GLYPH_COUNT finishes in the accept cycle. In a tick one shared
//   8-bit comparator walks the duty memory one entry per cycle through the
//   single memory read port.
//   s_axis_tready is high only when the sequencer is idle.
// Reset:
//   Synchronous, active low. All duties read as zero, the PWM count is zero
//   and the master intensity is 255.
// Stalls:
//   A finished word sits in the output register; the next word waits until
//   it is taken. After the last word the block is free for a new request.
// ----------------------------------------------------------------------------
module multichannel_pwm_with_master_dimming_top #(
    parameter int DEVICE_COUNT = mcpwm_pkg::DEF_DEVICE_COUNT,
    parameter int GLYPH_COUNT  = mcpwm_pkg::DEF_GLYPH_COUNT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [mcpwm_pkg::DATA_IN_W-1:0]   s_axis_tdata,   // [6:0] glyph_index, [14:7] level
    input  logic                              s_axis_tuser,   // [0] command
    // result channel
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [mcpwm_pkg::DATA_OUT_W-1:0]  m_axis_tdata,   // [1:0] device_index, [33:2] output_bits
    output logic                              m_axis_tlast,   // last_word
    // master intensity write
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mcpwm_pkg::DUTY_W-1:0]      i_cfg_data
);
    import mcpwm_pkg::*;

    localparam int TOTAL = DEVICE_COUNT * CHANNELS_PER_DEVICE;
    localparam int AW    = $clog2(TOTAL);
    localparam logic [GLYPH_W:0] TOTAL_M1 = (GLYPH_W+1)'(TOTAL - 1);
    localparam logic [DEV_W-1:0] DEV_LAST = DEV_W'(DEVICE_COUNT - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SET_MUL,
        ST_SET_WR,
        ST_TICK_RD,
        ST_TICK_DRAIN,
        ST_TICK_PUSH
    } t_state;

    t_state                   r_state;
    logic [DUTY_W-1:0]        r_master;
    logic [DUTY_W-1:0]        r_count;
    logic [DUTY_W-1:0]        r_level;
    logic [AW-1:0]            r_wr_addr;
    logic [DEV_W-1:0]         r_dev;
    logic [CHAN_W-1:0]        r_chan;
    logic                     r_pipe_vld;
    logic [CHAN_W-1:0]        r_pipe_chan;
    logic [CHANNELS_PER_DEVICE-1:0] r_acc;
    logic                     r_out_vld;
    logic [DEV_W-1:0]         r_out_dev;
    logic [CHANNELS_PER_DEVICE-1:0] r_out_bits;
    logic                     r_out_last;

    logic [GLYPH_W-1:0]       w_glyph;
    logic [DUTY_W-1:0]        w_level;
    logic                     w_glyph_ok;
    logic [DUTY_W-1:0]        w_duty;
    logic [DUTY_W-1:0]        w_rd_duty;
    logic [AW-1:0]            w_rd_addr;
    logic                     w_wr_en;
    logic                     w_push;

    assign w_glyph    = s_axis_tdata[GLYPH_W-1:0];
    assign w_level    = s_axis_tdata[GLYPH_W +: DUTY_W];
    assign w_glyph_ok = (32'(w_glyph) < GLYPH_COUNT) && (32'(w_glyph) < TOTAL);
    assign w_wr_en    = (r_state == ST_SET_WR);
    // channel c of device d sits at d*32 + c
    assign w_rd_addr  = AW'({r_dev, r_chan});
    // load a finished word once the output register is free
    assign w_push     = (r_state == ST_TICK_PUSH) && (!r_out_vld || m_axis_tready);

    mcpwm_scale u_scale (
        .i_clk    (i_clk),
        .i_level  (r_level),
        .i_master (r_master),
        .o_duty   (w_duty)
    );

    mcpwm_store #(
        .DEPTH (TOTAL),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_wr_addr),
        .i_wr_data (w_duty),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_duty)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_master   <= MASTER_RESET;
            r_count    <= '0;
            r_pipe_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_master <= i_cfg_data;
            end
            // refill the output register on a push, else drop the word once taken
            if (w_push) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            // a read issued this cycle returns its duty next cycle
            r_pipe_vld <= (r_state == ST_TICK_RD);
            // shared comparator: duty read last cycle against the current count
            if (r_pipe_vld && (w_rd_duty > r_count)) begin
                r_acc[r_pipe_chan] <= 1'b1;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        if (s_axis_tuser == CMD_TICK) begin
                            r_dev   <= '0;
                            r_chan  <= '0;
                            r_acc   <= '0;
                            r_state <= ST_TICK_RD;
                        end else if (w_glyph_ok) begin
                            r_level   <= w_level;
                            // mirror the glyph from the top of the store
                            r_wr_addr <= AW'(TOTAL_M1 - {1'b0, w_glyph});
                            r_state   <= ST_SET_MUL;
                        end
                    end
                end
                ST_SET_MUL: begin
                    r_state <= ST_SET_WR;
                end
                ST_SET_WR: begin
                    r_state <= ST_IDLE;
                end
                ST_TICK_RD: begin
                    r_pipe_chan <= r_chan;
                    r_chan      <= r_chan + CHAN_W'(1);
                    if (r_chan == CHAN_LAST) begin
                        r_state <= ST_TICK_DRAIN;
                    end
                end
                ST_TICK_DRAIN: begin
                    r_state <= ST_TICK_PUSH;
                end
                ST_TICK_PUSH: begin
                    // hold the word until the output register is free
                    if (w_push) begin
                        r_out_dev  <= r_dev;
                        r_out_bits <= r_acc;
                        r_out_last <= (r_dev == DEV_LAST);
                        if (r_dev == DEV_LAST) begin
                            r_count <= r_count + DUTY_W'(1);
                            r_state <= ST_IDLE;
                        end else begin
                            r_dev   <= r_dev + DEV_W'(1);
                            r_chan  <= '0;
                            r_acc   <= '0;
                            r_state <= ST_TICK_RD;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {(DATA_OUT_W - DEV_W - CHANNELS_PER_DEVICE)'(0), r_out_bits,
                            r_out_dev};
    assign m_axis_tlast  = r_out_last;

endmodule

FILE: dv/multichannel_pwm_with_master_dimming_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_pwm_with_master_dimming_top_tb
// Self-checking bench for the 96-channel PWM generator with master dimming.
// A short table of set and tick requests exercises the glyph mirroring, the
// ignored glyphs and the duty extremes. Random requests then follow under
// several master intensities and flow-control patterns. Every tick word is
// checked against hand-written words or a model of duty store and PWM count.
// ----------------------------------------------------------------------------
module multichannel_pwm_with_master_dimming_top_tb;
    import mcpwm_pkg::*;

    localparam int NUM_DEVICES  = DEF_DEVICE_COUNT;
    localparam int NUM_GLYPHS   = DEF_GLYPH_COUNT;
    localparam int NUM_CHANNELS = NUM_DEVICES * CHANNELS_PER_DEVICE;
    localparam int NUM_PHASES   = 5;
    localparam int PHASE_ITEMS  = 50;
    // A set finishes after its multiply and memory write states; leave some margin.
    localparam int SET_SETTLE   = 8;
    // Wait beyond the length of a tick at the end.
    localparam int END_SETTLE   = 120;
    localparam int LONG_HOLD    = 400;

    // One expected tick word, as it should leave the result channel.
    typedef struct packed {
        logic [DEV_W-1:0] dev;
        logic [31:0]      bits;
        logic             last;
    } t_pwm_word;

    // One request; typed rows carry their tick words written out by hand.
    typedef struct packed {
        logic                        cmd;
        logic [GLYPH_W-1:0]          glyph;
        logic [DUTY_W-1:0]           level;
        logic                        typed;
        logic [NUM_DEVICES-1:0][31:0] words;
    } t_pwm_request;

    // ------------------------------------------------------------------
    // DUT connections: every input is known from time zero
    // ------------------------------------------------------------------
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [DATA_IN_W-1:0]  s_axis_tdata  = '0;   // [6:0] glyph_index, [14:7] level
    logic                  s_axis_tuser  = 1'b0; // [0] command
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [DATA_OUT_W-1:0] m_axis_tdata;         // [1:0] device_index, [33:2] output_bits
    logic                  m_axis_tlast;         // last_word
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [DUTY_W-1:0]     i_cfg_data    = '0;

    // Model of the block: duty per channel, PWM count and master intensity.
    logic [DUTY_W-1:0] duty_model [NUM_CHANNELS];
    logic [DUTY_W-1:0] count_model;
    logic [DUTY_W-1:0] master_model;
    t_pwm_word         expected_words [$];

    int err_count      = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // Bumped by the stimulus to ask the receiver for one long hold-off.
    int hold_seq       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;

    multichannel_pwm_with_master_dimming_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Count a mismatch and print one line for it.
    task automatic report_mismatch(input string msg);
        err_count++;
        $display("t=%0t mismatch: %s", $time, msg);
    endtask

    // Scale a level by the master intensity with rounding, clamp at 254.
    function automatic logic [DUTY_W-1:0] dimmed_duty(input logic [DUTY_W-1:0] level);
        int unsigned scaled;
        scaled = (32'(level) * 32'(master_model) + 32'd127) / 32'd255;
        if (scaled >= 32'(DUTY_CLAMP)) begin
            return DUTY_CLAMP;
        end
        return scaled[DUTY_W-1:0];
    endfunction

    // Advance the model by one accepted request and queue the tick words.
    task automatic apply_request(input t_pwm_request req);
        t_pwm_word word;
        if (req.cmd == CMD_SET) begin
            // Glyphs mirror from the top of the store; out-of-range ones drop.
            if (req.glyph < NUM_GLYPHS && req.glyph < NUM_CHANNELS) begin
                duty_model[NUM_CHANNELS - 1 - req.glyph] = dimmed_duty(req.level);
            end
        end else begin
            // Compare against the count as it was before this tick.
            for (int d = 0; d < NUM_DEVICES; d++) begin
                word.dev  = DEV_W'(d);
                word.last = (d == NUM_DEVICES - 1);
                word.bits = '0;
                for (int c = 0; c < CHANNELS_PER_DEVICE; c++) begin
                    word.bits[c] = duty_model[d * CHANNELS_PER_DEVICE + c] > count_model;
                end
                if (req.typed) begin
                    word.bits = req.words[d];
                end
                expected_words.push_back(word);
            end
            count_model = count_model + 1'b1;
        end
    endtask

    // Offer one request after a random gap and hold it until it is taken.
    task automatic send_request(input t_pwm_request req);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = req.cmd;
        s_axis_tdata  = {1'b0, req.level, req.glyph};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        apply_request(req);
    endtask

    // Drop valid and hold off until every tick word is out and sets have settled.
    task automatic wait_until_idle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (expected_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SET_SETTLE) @(posedge i_clk);
    endtask

    // Write the master intensity while the block is idle.
    task automatic write_master(input logic [DUTY_W-1:0] value);
        wait_until_idle();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        master_model = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Mostly in-range sets and ticks, with a share of glyphs the block ignores.
    function automatic t_pwm_request random_request();
        t_pwm_request req;
        req     = '0;
        req.cmd = ($urandom_range(99) < 45) ? CMD_TICK : CMD_SET;
        if ($urandom_range(99) < 85) begin
            req.glyph = GLYPH_W'($urandom_range(NUM_GLYPHS - 1));
        end else begin
            req.glyph = GLYPH_W'($urandom_range(127, NUM_GLYPHS));
        end
        case ($urandom_range(9))
            0: begin
                req.level = '0;
            end
            1: begin
                req.level = '1;
            end
            default: begin
                req.level = DUTY_W'($urandom);
            end
        endcase
        return req;
    endfunction

    // ------------------------------------------------------------------
    // Receiver: stall at random, or hold off for a long stretch on request
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready = 1'b0;
        end else begin
            m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result check: each accepted word against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : word_check
        t_pwm_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word tdata=%0h tlast=%0b",
                                          m_axis_tdata, m_axis_tlast));
            end else begin
                want = expected_words.pop_front();
                if (m_axis_tdata[DEV_W-1:0] !== want.dev) begin
                    report_mismatch($sformatf("device_index expected %0d, got %0d",
                                              want.dev, m_axis_tdata[DEV_W-1:0]));
                end
                if (m_axis_tdata[DEV_W+31:DEV_W] !== want.bits) begin
                    report_mismatch($sformatf("output_bits dev %0d expected %08h, got %08h",
                                              want.dev, want.bits,
                                              m_axis_tdata[DEV_W+31:DEV_W]));
                end
                if (m_axis_tlast !== want.last) begin
                    report_mismatch($sformatf("last_word dev %0d expected %0b, got %0b",
                                              want.dev, want.last, m_axis_tlast));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_pwm_request      dir_rows [$];
        t_pwm_request      req;
        logic [DUTY_W-1:0] phase_master [NUM_PHASES];
        int                phase_idle   [NUM_PHASES];
        int                phase_stall  [NUM_PHASES];
        int                counted;

        // Model starts from the reset state: empty store, count zero.
        foreach (duty_model[i]) begin
            duty_model[i] = '0;
        end
        count_model  = '0;
        master_model = MASTER_RESET;

        // Directed table; only the obvious tick words are written out.
        // A tick straight after reset sees an empty store.
        dir_rows.push_back(t_pwm_request'{CMD_TICK, 7'd0,   8'd0,   1'b1, {32'h0, 32'h0, 32'h0}});
        // Full level at both ends of the glyph range, then two ignored glyphs.
        dir_rows.push_back(t_pwm_request'{CMD_SET,  7'd0,   8'd255, 1'b0, '0});
        dir_rows.push_back(t_pwm_request'{CMD_SET,  7'd95,  8'd255, 1'b0, '0});
        dir_rows.push_back(t_pwm_request'{CMD_SET,  7'd96,  8'd255, 1'b0, '0});
        dir_rows.push_back(t_pwm_request'{CMD_SET,  7'd127, 8'd255, 1'b0, '0});
        // Glyph 0 lands on device 2 bit 31, glyph 95 on device 0 bit 0.
        dir_rows.push_back(t_pwm_request'{CMD_TICK, 7'd0,   8'd0,   1'b1,
                                          {32'h8000_0000, 32'h0, 32'h0000_0001}});
        dir_rows.push_back(t_pwm_request'{CMD_SET,  7'd63,  8'd1,   1'b0, '0});
        dir_rows.push_back(t_pwm_request'{CMD_SET,  7'd32,  8'd128, 1'b0, '0});
        dir_rows.push_back(t_pwm_request'{CMD_TICK, 7'd127, 8'd255, 1'b0, '0});
        // Clear the two extremes again with a zero level.
        dir_rows.push_back(t_pwm_request'{CMD_SET,  7'd0,   8'd0,   1'b0, '0});
        dir_rows.push_back(t_pwm_request'{CMD_SET,  7'd95,  8'd0,   1'b0, '0});
        dir_rows.push_back(t_pwm_request'{CMD_TICK, 7'd0,   8'd0,   1'b0, '0});
        // Alternating bit patterns on glyph and level, then levels 8'h7F and 8'h80.
        dir_rows.push_back(t_pwm_request'{CMD_SET,  7'd42,  8'h55,  1'b0, '0});
        dir_rows.push_back(t_pwm_request'{CMD_SET,  7'd85,  8'hAA,  1'b0, '0});
        dir_rows.push_back(t_pwm_request'{CMD_SET,  7'd21,  8'h7F,  1'b0, '0});
        dir_rows.push_back(t_pwm_request'{CMD_SET,  7'd64,  8'h80,  1'b0, '0});
        dir_rows.push_back(t_pwm_request'{CMD_TICK, 7'd85,  8'hAA,  1'b0, '0});
        dir_rows.push_back(t_pwm_request'{CMD_TICK, 7'd42,  8'h55,  1'b0, '0});

        // Random phases: master setting and flow-control pattern for each.
        phase_master = '{8'd0, 8'd1, 8'd128, DUTY_W'($urandom_range(255)), 8'd255};
        phase_idle   = '{0, 55, 0, 33, 0};
        phase_stall  = '{0, 0, 55, 33, 0};

        // Hold reset, then release it on a falling edge.
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            send_request(dir_rows[i]);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            // Pause the sender until the block is idle, then change the master.
            write_master(phase_master[p]);
            send_idle_pct  = phase_idle[p];
            recv_stall_pct = phase_stall[p];
            // Last phase: starve the output so the block backs up its input.
            if (p == NUM_PHASES - 1) begin
                hold_seq++;
            end
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                req = random_request();
                send_request(req);
                // Ignored glyphs do not count towards the phase length.
                if (!(req.cmd == CMD_SET && req.glyph >= NUM_GLYPHS)) begin
                    counted++;
                end
            end
        end

        // Drain the remaining tick words, then give the block time to settle.
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (expected_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (END_SETTLE) @(posedge i_clk);

        if (err_count == 0 && expected_words.size() == 0) begin
            $display("multichannel_pwm_with_master_dimming_top_tb: PASS");
        end else begin
            $display("multichannel_pwm_with_master_dimming_top_tb: FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #2_000_000;
        $display("multichannel_pwm_with_master_dimming_top_tb: FAIL");
        $finish;
    end

endmodule
